// ===== hw/rtl/i2cbb_pkg.sv =====
package i2cbb_pkg;

	// Command codes carried by an input beat
	localparam logic [2:0] CMD_NONE  = 3'd0;
	localparam logic [2:0] CMD_START = 3'd1;
	localparam logic [2:0] CMD_STOP  = 3'd2;
	localparam logic [2:0] CMD_WRITE = 3'd3;
	localparam logic [2:0] CMD_READ  = 3'd4;

	// Clock bits per byte transfer, acknowledge included
	localparam logic [3:0] BITS_PER_XFER = 4'd9;
	localparam logic [3:0] DATA_BITS     = 4'd8;

	localparam logic [7:0] PHASE_TICKS_RST = 8'd8;

	// Operation in progress
	typedef enum logic [4:0] {
		OP_IDLE  = 5'b00001,
		OP_START = 5'b00010,
		OP_STOP  = 5'b00100,
		OP_WRITE = 5'b01000,
		OP_READ  = 5'b10000
	} op_t;

	typedef struct packed {
		logic [2:0] command;
		logic [7:0] write_byte;
		logic       send_ack;
		logic       sda_in;
	} tick_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_release;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_data;
	} res_t;

endpackage

// ===== hw/rtl/i2cbb_seq.sv =====
module i2cbb_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  i2cbb_pkg::tick_t  tick,
	input  logic [7:0]        phase_ticks,
	output i2cbb_pkg::res_t   res
);
	import i2cbb_pkg::*;

	op_t        op_q, op_n;
	logic       phase_q, phase_n;
	logic [3:0] bit_q, bit_n;
	logic [7:0] tick_q, tick_n;
	logic [7:0] shift_q, shift_n;
	logic       ack_q, ack_n;
	logic       scl_q, scl_n;
	logic       sda_q, sda_n;
	logic [7:0] rdata_q, rdata_n;
	logic       done_n;
	logic [7:0] limit;

	// SDA level to set up for a data or acknowledge bit
	function automatic logic bit_level(input op_t op, input logic [3:0] idx,
			input logic [7:0] sh, input logic ack);
		logic lvl;
		if (idx < DATA_BITS) begin
			lvl = (op == OP_WRITE) ? sh[3'd7 - idx[2:0]] : 1'b1;
		end else begin
			lvl = (op == OP_WRITE) ? 1'b1 : !ack;
		end
		return lvl;
	endfunction

	assign limit = (phase_ticks == 8'd0) ? 8'd1 : phase_ticks;

	// Next state for one tick
	always_comb begin
		op_n    = op_q;
		phase_n = phase_q;
		bit_n   = bit_q;
		tick_n  = tick_q;
		shift_n = shift_q;
		ack_n   = ack_q;
		scl_n   = scl_q;
		sda_n   = sda_q;
		rdata_n = rdata_q;
		done_n  = 1'b0;
		if (op_q == OP_IDLE) begin
			// Take a new command and set the lines of its first phase
			phase_n = 1'b0;
			bit_n   = 4'd0;
			tick_n  = 8'd0;
			case (tick.command)
				CMD_START: begin
					op_n  = OP_START;
					scl_n = 1'b1;
					sda_n = 1'b1;
				end
				CMD_STOP: begin
					op_n  = OP_STOP;
					scl_n = 1'b1;
					sda_n = 1'b0;
				end
				CMD_WRITE: begin
					op_n    = OP_WRITE;
					shift_n = tick.write_byte;
					ack_n   = tick.send_ack;
					scl_n   = 1'b0;
					sda_n   = tick.write_byte[7];
				end
				CMD_READ: begin
					op_n    = OP_READ;
					shift_n = 8'd0;
					ack_n   = tick.send_ack;
					scl_n   = 1'b0;
					sda_n   = 1'b1;
				end
				default: begin
					tick_n = tick_q;
					phase_n = phase_q;
					bit_n  = bit_q;
				end
			endcase
		end else begin
			tick_n = tick_q + 8'd1;
			if (tick_n >= limit) begin
				tick_n = 8'd0;
				if (op_q == OP_START || op_q == OP_STOP) begin
					// Data edge while SCL high, then finish
					if (!phase_q) begin
						sda_n   = (op_q == OP_STOP);
						phase_n = 1'b1;
					end else begin
						done_n = 1'b1;
					end
				end else if (!phase_q) begin
					// Raise SCL for the high half of the bit
					scl_n   = 1'b1;
					phase_n = 1'b1;
				end else begin
					// Sample on a read, drop SCL, advance to the next bit
					if (op_q == OP_READ && bit_q < DATA_BITS && tick.sda_in) begin
						shift_n = shift_q | (8'h80 >> bit_q[2:0]);
					end
					scl_n = 1'b0;
					bit_n = bit_q + 4'd1;
					if (bit_n >= BITS_PER_XFER) begin
						if (op_q == OP_READ) begin
							rdata_n = shift_n;
						end
						done_n = 1'b1;
					end else begin
						sda_n   = bit_level(op_q, bit_n, shift_n, ack_q);
						phase_n = 1'b0;
					end
				end
				if (done_n) begin
					op_n    = OP_IDLE;
					phase_n = 1'b0;
					bit_n   = 4'd0;
				end
			end
		end
	end

	// Hold state between ticks, advance on each processed beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q    <= OP_IDLE;
			phase_q <= 1'b0;
			bit_q   <= 4'd0;
			tick_q  <= 8'd0;
			shift_q <= 8'd0;
			ack_q   <= 1'b0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			rdata_q <= 8'd0;
		end else if (step) begin
			op_q    <= op_n;
			phase_q <= phase_n;
			bit_q   <= bit_n;
			tick_q  <= tick_n;
			shift_q <= shift_n;
			ack_q   <= ack_n;
			scl_q   <= scl_n;
			sda_q   <= sda_n;
			rdata_q <= rdata_n;
		end
	end

	assign res.scl_level   = scl_n;
	assign res.sda_release = sda_n;
	assign res.busy_res    = (op_n != OP_IDLE);
	assign res.done_res    = done_n;
	assign res.read_data   = rdata_n;

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		step && done_n |-> !res.busy_res)
		else $error("done with busy still set");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		op_q == OP_IDLE |-> !phase_q && bit_q == 4'd0)
		else $error("idle with phase or bit index left over");

	a_bit_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_q < BITS_PER_XFER)
		else $error("bit index out of range");

	a_done_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		step && done_n |-> op_q != OP_IDLE)
		else $error("done without a command in progress");

endmodule

// ===== hw/rtl/i2c_bitbang_master.sv =====
// Tick-driven I2C master byte controller.
// cmd channel (cmd_valid/cmd_stall/cmd): one beat per tick, carrying an optional
// command (start, stop, write byte, read byte), the byte to write, the ack choice
// for a read and the sampled SDA level. A command is taken only while idle.
// res channel (res_valid/res_stall/res): one beat per tick with the SCL and SDA
// levels to drive, busy, a done pulse and the last byte read.
// cfg channel (cfg_valid/cfg_ready/cfg_data): writes phase_ticks, the ticks per
// line phase; cfg_ready is always high. Write it only while the block is idle.
// A cmd beat passes through the input register, then the sequencer step feeds
// the result register. The block takes one beat per cycle while res_stall is low,
// as the sequencer steps once per beat.
// When res_stall is high the finished beat holds in the result register while one
// more beat waits in the input register; cmd_stall rises only when both are full.
// Reset sets the sequencer's line state to released (SCL and SDA high), leaves the block
// idle with phase_ticks at 8 and the read byte at zero.
module i2c_bitbang_master (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  i2cbb_pkg::tick_t  cmd,
	output logic              res_valid,
	input  logic              res_stall,
	output i2cbb_pkg::res_t   res,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [7:0]        cfg_data
);
	import i2cbb_pkg::*;

	logic       valid_s1;
	tick_t      tick_s1;
	logic       res_valid_q;
	res_t       res_q;
	res_t       res_n;
	logic [7:0] phase_ticks_q;
	logic       res_take;
	logic       adv;
	logic       accept;

	assign res_take  = !res_valid_q || !res_stall;
	assign adv       = valid_s1 && res_take;
	assign cmd_stall = valid_s1 && !res_take;
	assign accept    = cmd_valid && !cmd_stall;
	assign cfg_ready = 1'b1;

	// Hold the configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q <= PHASE_TICKS_RST;
		end else if (cfg_valid && cfg_ready) begin
			phase_ticks_q <= cfg_data;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tick_s1 <= cmd;
		end
	end

	i2cbb_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (adv),
		.tick        (tick_s1),
		.phase_ticks (phase_ticks_q),
		.res         (res_n)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_n;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ===== bench/i2c_bitbang_master_tb.sv =====
module i2c_bitbang_master_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import i2cbb_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int HOLD_CYCLES = 300;

	logic   clk;
	logic   arst_n;
	logic   cmd_valid;
	logic   cmd_stall;
	tick_t  cmd;
	logic   res_valid;
	logic   res_stall;
	res_t   res;
	logic   cfg_valid;
	logic   cfg_ready;
	logic   [7:0] cfg_data;

	// Bus sequencer mirror
	op_t        bus_op;
	logic       bus_phase;
	logic [3:0] bit_no;
	logic [7:0] tick_cnt;
	logic [7:0] shreg;
	logic       ack_sel;
	logic       scl_q;
	logic       sda_q;
	logic [7:0] rd_byte;
	logic [7:0] ptick_reg;

	// Expected line levels, oldest first
	res_t want_lines[$];

	int err_cnt;
	int cycle_cnt;
	int res_count;
	int res_seen;
	int stall_left;
	int gap_max;
	int stall_max;
	bit hold_active;
	bit in_xfer;

	i2c_bitbang_master dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// SDA level set up for the current bit of a byte transfer
	function automatic logic next_sda();
		if (bus_op == OP_WRITE)
			return (bit_no < DATA_BITS) ? shreg[3'(7 - bit_no)] : 1'b1;
		return (bit_no < DATA_BITS) ? 1'b1 : ~ack_sel;
	endfunction

	// Close one delay phase; return 1 when the command completes
	function automatic logic end_phase(logic sda);
		if (bus_op == OP_START || bus_op == OP_STOP) begin
			if (bus_phase == 1'b0) begin
				sda_q = (bus_op == OP_START) ? 1'b0 : 1'b1;
				bus_phase = 1'b1;
				return 1'b0;
			end
			return 1'b1;
		end
		if (bus_phase == 1'b0) begin
			scl_q = 1'b1;
			bus_phase = 1'b1;
			return 1'b0;
		end
		if (bus_op == OP_READ && bit_no < DATA_BITS && sda)
			shreg[3'(7 - bit_no)] = 1'b1;
		scl_q = 1'b0;
		bit_no = bit_no + 4'd1;
		if (bit_no >= BITS_PER_XFER) begin
			if (bus_op == OP_READ)
				rd_byte = shreg;
			return 1'b1;
		end
		sda_q = next_sda();
		bus_phase = 1'b0;
		return 1'b0;
	endfunction

	// Advance the mirror by one tick and return the line levels it drives
	function automatic res_t next_bus_levels(tick_t t);
		res_t r;
		logic fin;
		logic [7:0] lim;
		lim = (ptick_reg == 8'd0) ? 8'd1 : ptick_reg;
		fin = 1'b0;
		if (bus_op == OP_IDLE) begin
			case (t.command)
				CMD_START: begin
					bus_op = OP_START;
					scl_q = 1'b1;
					sda_q = 1'b1;
				end
				CMD_STOP: begin
					bus_op = OP_STOP;
					scl_q = 1'b1;
					sda_q = 1'b0;
				end
				CMD_WRITE, CMD_READ: begin
					bus_op = (t.command == CMD_WRITE) ? OP_WRITE : OP_READ;
					bit_no = 4'd0;
					shreg = (t.command == CMD_WRITE) ? t.write_byte : 8'h00;
					ack_sel = t.send_ack;
					scl_q = 1'b0;
					sda_q = next_sda();
				end
				default: ;
			endcase
			if (bus_op != OP_IDLE) begin
				bus_phase = 1'b0;
				bit_no = 4'd0;
				tick_cnt = 8'd0;
			end
		end else begin
			tick_cnt = tick_cnt + 8'd1;
			if (tick_cnt >= lim) begin
				tick_cnt = 8'd0;
				fin = end_phase(t.sda_in);
				if (fin) begin
					bus_op = OP_IDLE;
					bus_phase = 1'b0;
					bit_no = 4'd0;
				end
			end
		end
		r.scl_level = scl_q;
		r.sda_release = sda_q;
		r.busy_res = (bus_op != OP_IDLE);
		r.done_res = fin;
		r.read_data = rd_byte;
		return r;
	endfunction

	task automatic report(string msg);
		$display("MISMATCH cycle %0d: %s", cycle_cnt, msg);
		err_cnt++;
	endtask

	// Offer one tick beat after a random gap and queue its expected levels
	task automatic send_tick(tick_t t);
		int gap;
		gap = $urandom_range(0, gap_max);
		@(negedge clk);
		if (gap != 0) begin
			cmd_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd = t;
		cmd_valid = 1'b1;
		do @(posedge clk); while (cmd_stall);
		want_lines.push_back(next_bus_levels(t));
	endtask

	// Issue one command, then tick until the sequencer is idle again.
	// During a read, sda_in follows pat MSB first; noisy puts commands on busy ticks.
	task automatic do_cmd(logic [2:0] c, logic [7:0] wb, logic ack, logic [7:0] pat,
			bit noisy);
		tick_t t;
		t.command = c;
		t.write_byte = wb;
		t.send_ack = ack;
		t.sda_in = 1'($urandom);
		send_tick(t);
		while (bus_op != OP_IDLE) begin
			t.command = noisy ? 3'($urandom_range(0, 7)) : CMD_NONE;
			t.write_byte = 8'($urandom);
			t.send_ack = 1'($urandom);
			t.sda_in = (bit_no < DATA_BITS) ? pat[3'(7 - bit_no)] : 1'($urandom);
			send_tick(t);
		end
	endtask

	// Finish the command in flight, drop valid and wait for every result
	task automatic drain_bus();
		do_cmd(CMD_NONE, 8'h00, 1'b0, 8'h00, 1'b0);
		@(negedge clk);
		cmd_valid = 1'b0;
		while (want_lines.size() != 0) @(posedge clk);
	endtask

	task automatic set_phase_ticks(logic [7:0] v);
		drain_bus();
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = v;
		do @(posedge clk); while (!cfg_ready);
		ptick_reg = v;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Random transactions: start, writes and reads, stop, with some noise
	task automatic bus_traffic(int n);
		tick_t t;
		int r;
		for (int i = 0; i < n; i++) begin
			t.write_byte = 8'($urandom);
			t.send_ack = 1'($urandom);
			t.sda_in = 1'($urandom);
			t.command = CMD_NONE;
			r = $urandom_range(0, 99);
			if (bus_op == OP_IDLE) begin
				if (r < 8)
					t.command = CMD_NONE;
				else if (r < 14)
					t.command = 3'($urandom_range(0, 7));
				else if (!in_xfer) begin
					t.command = CMD_START;
					in_xfer = 1'b1;
				end else if (r < 60)
					t.command = CMD_WRITE;
				else if (r < 85)
					t.command = CMD_READ;
				else if (r < 95) begin
					t.command = CMD_STOP;
					in_xfer = 1'b0;
				end else
					t.command = CMD_START;
			end else if (r < 10)
				t.command = 3'($urandom_range(0, 7));
			send_tick(t);
		end
	endtask

	task automatic test_reset_phase();
		do_cmd(CMD_START, 8'h00, 1'b0, 8'h00, 1'b0);
		do_cmd(CMD_WRITE, 8'hC3, 1'b0, 8'h00, 1'b0);
		do_cmd(CMD_STOP, 8'h00, 1'b0, 8'h00, 1'b0);
	endtask

	task automatic test_byte_extremes();
		set_phase_ticks(8'd1);
		do_cmd(CMD_START, 8'h00, 1'b0, 8'h00, 1'b0);
		do_cmd(CMD_WRITE, 8'hFF, 1'b1, 8'h00, 1'b0);
		do_cmd(CMD_WRITE, 8'h00, 1'b0, 8'hFF, 1'b0);
		do_cmd(CMD_READ, 8'h00, 1'b1, 8'hFF, 1'b0);
		do_cmd(CMD_READ, 8'hFF, 1'b0, 8'h00, 1'b0);
		do_cmd(CMD_READ, 8'h5A, 1'b1, 8'hA5, 1'b0);
		do_cmd(CMD_STOP, 8'h00, 1'b0, 8'h00, 1'b0);
	endtask

	task automatic test_busy_and_unknown();
		do_cmd(3'd5, 8'hFF, 1'b1, 8'h00, 1'b0);
		do_cmd(3'd6, 8'h00, 1'b0, 8'h00, 1'b0);
		do_cmd(3'd7, 8'hAA, 1'b1, 8'h00, 1'b0);
		do_cmd(CMD_NONE, 8'h55, 1'b1, 8'h00, 1'b0);
		do_cmd(CMD_START, 8'h00, 1'b0, 8'h00, 1'b1);
		do_cmd(CMD_WRITE, 8'h5A, 1'b0, 8'h00, 1'b1);
		do_cmd(CMD_READ, 8'h00, 1'b0, 8'h3C, 1'b1);
		do_cmd(CMD_STOP, 8'h00, 1'b0, 8'h00, 1'b1);
	endtask

	task automatic test_phase_extremes();
		// zero phase length behaves as one tick
		set_phase_ticks(8'd0);
		do_cmd(CMD_START, 8'h00, 1'b0, 8'h00, 1'b0);
		do_cmd(CMD_WRITE, 8'h81, 1'b0, 8'h00, 1'b0);
		do_cmd(CMD_READ, 8'h00, 1'b1, 8'h7E, 1'b0);
		do_cmd(CMD_STOP, 8'h00, 1'b0, 8'h00, 1'b0);
		// longest phase: keep both sides eager so this stays short
		gap_max = 0;
		stall_max = 0;
		set_phase_ticks(8'd255);
		do_cmd(CMD_START, 8'h00, 1'b0, 8'h00, 1'b0);
		do_cmd(CMD_STOP, 8'h00, 1'b0, 8'h00, 1'b1);
		gap_max = 14;
		stall_max = 14;
		set_phase_ticks(8'd2);
		do_cmd(CMD_START, 8'h00, 1'b0, 8'h00, 1'b0);
		do_cmd(CMD_READ, 8'h00, 1'b0, 8'h96, 1'b0);
		do_cmd(CMD_STOP, 8'h00, 1'b0, 8'h00, 1'b0);
	endtask

	// Hold the result side for a long stretch while ticks keep coming
	task automatic test_backpressure();
		set_phase_ticks(8'd1);
		gap_max = 0;
		fork
			begin
				@(posedge clk);
				hold_active = 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_active = 1'b0;
			end
		join_none
		bus_traffic(80);
		gap_max = 14;
	endtask

	task automatic test_random_traffic();
		logic [7:0] pt;
		for (int seg = 0; seg < 8; seg++) begin
			case (seg)
				0: pt = 8'd1;
				1: pt = 8'd0;
				2: pt = 8'd2;
				3: pt = 8'd3;
				default: pt = 8'($urandom_range(1, 12));
			endcase
			set_phase_ticks(pt);
			gap_max = (seg % 3 == 1) ? 0 : 14;
			stall_max = (seg % 3 == 2) ? 0 : 14;
			bus_traffic(60);
		end
	endtask

	// Check each accepted result beat against the oldest expectation
	always @(posedge clk) begin
		res_t w;
		if (arst_n && res_valid && !res_stall) begin
			if (want_lines.size() == 0)
				report("result beat with nothing pending");
			else begin
				w = want_lines.pop_front();
				if (res.scl_level !== w.scl_level)
					report($sformatf("scl_level got %b want %b", res.scl_level, w.scl_level));
				if (res.sda_release !== w.sda_release)
					report($sformatf("sda_release got %b want %b",
						res.sda_release, w.sda_release));
				if (res.busy_res !== w.busy_res)
					report($sformatf("busy_res got %b want %b", res.busy_res, w.busy_res));
				if (res.done_res !== w.done_res)
					report($sformatf("done_res got %b want %b", res.done_res, w.done_res));
				if (res.read_data !== w.read_data)
					report($sformatf("read_data got %h want %h", res.read_data, w.read_data));
			end
			res_count++;
		end
	end

	// Draw a stall length after each accepted result beat
	always @(negedge clk) begin
		if (res_count != res_seen) begin
			res_seen = res_count;
			stall_left = $urandom_range(0, stall_max);
		end
		if (stall_left != 0) begin
			res_stall = 1'b1;
			stall_left--;
		end else
			res_stall = hold_active;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		res_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = 8'd0;
		hold_active = 1'b0;
		in_xfer = 1'b0;
		err_cnt = 0;
		cycle_cnt = 0;
		res_count = 0;
		res_seen = 0;
		stall_left = 0;
		gap_max = 14;
		stall_max = 14;
		bus_op = OP_IDLE;
		bus_phase = 1'b0;
		bit_no = 4'd0;
		tick_cnt = 8'd0;
		shreg = 8'h00;
		ack_sel = 1'b0;
		scl_q = 1'b1;
		sda_q = 1'b1;
		rd_byte = 8'h00;
		ptick_reg = PHASE_TICKS_RST;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		test_reset_phase();
		test_byte_extremes();
		test_busy_and_unknown();
		test_phase_extremes();
		test_backpressure();
		test_random_traffic();

		// drop valid, collect the tail, then let the pipeline settle
		@(negedge clk);
		cmd_valid = 1'b0;
		while (want_lines.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (err_cnt == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== i2c_bitbang_master.f =====
hw/rtl/i2cbb_pkg.sv
hw/rtl/i2cbb_seq.sv
hw/rtl/i2c_bitbang_master.sv
bench/i2c_bitbang_master_tb.sv
